>>> rtl/mdu_pkg.sv
// shared types and constants for the rv64 multiply and divide unit
`default_nettype none
package mdu_pkg;

   // operation codes of the request
   typedef enum logic [3:0] {
      OP_MUL    = 4'd0,
      OP_MULH   = 4'd1,
      OP_MULHSU = 4'd2,
      OP_MULHU  = 4'd3,
      OP_DIV    = 4'd4,
      OP_DIVU   = 4'd5,
      OP_MULW   = 4'd6,
      OP_DIVW   = 4'd7,
      OP_DIVUW  = 4'd8
   } op_type;

   localparam int Xlen     = 64;
   localparam int DivSteps = 64;
   localparam int MulLat   = 3;
   localparam int MulDelay = DivSteps - MulLat;

   // control that rides along with each request
   typedef struct packed {
      logic valid;
      logic is_div;
      logic neg;
      logic word;
      logic divzero;
   } ctl_type;

endpackage
`default_nettype wire

>>> rtl/mdu_mul.sv
// three stage 64x64 multiplier with high-part sign correction
`default_nettype none
module mdu_mul (
   input  wire logic                   clock,
   input  wire logic                   en,
   input  wire mdu_pkg::op_type        op,
   input  wire logic [mdu_pkg::Xlen-1:0] operand_a,
   input  wire logic [mdu_pkg::Xlen-1:0] operand_b,
   output logic      [mdu_pkg::Xlen-1:0] product
);

   // stage 1 registers: partial products and correction
   logic [63:0] ll_ff, lh_ff, hl_ff, hh_ff, corr_ff;
   logic [63:0] ll_in, lh_in, hl_in, hh_in, corr_in;
   mdu_pkg::op_type op1_ff;
   // stage 2 registers: column sums
   logic [33:0] mid_ff, mid_in;
   logic [31:0] lo_ff;
   logic [63:0] hsum_ff, hsum_in, corr2_ff;
   mdu_pkg::op_type op2_ff;
   // stage 3 register: selected result
   logic [63:0] prod_ff, prod_in;
   logic [63:0] hi;

   // four 32x32 partial products
   always_comb begin
      ll_in = {32'b0, operand_a[31:0]} * {32'b0, operand_b[31:0]};
      lh_in = {32'b0, operand_a[31:0]} * {32'b0, operand_b[63:32]};
      hl_in = {32'b0, operand_a[63:32]} * {32'b0, operand_b[31:0]};
      hh_in = {32'b0, operand_a[63:32]} * {32'b0, operand_b[63:32]};
      corr_in = (((op == mdu_pkg::OP_MULH) || (op == mdu_pkg::OP_MULHSU)) && operand_a[63]
                 ? operand_b : 64'b0)
              + ((op == mdu_pkg::OP_MULH) && operand_b[63] ? operand_a : 64'b0);
   end

   // column sums
   always_comb begin
      mid_in  = {2'b0, ll_ff[63:32]} + {2'b0, lh_ff[31:0]} + {2'b0, hl_ff[31:0]};
      hsum_in = hh_ff + {32'b0, lh_ff[63:32]} + {32'b0, hl_ff[63:32]};
   end

   // final high part and result select
   always_comb begin
      hi = hsum_ff + {62'b0, mid_ff[33:32]} - corr2_ff;
      case (op2_ff)
         mdu_pkg::OP_MUL:    prod_in = {mid_ff[31:0], lo_ff};
         mdu_pkg::OP_MULH,
         mdu_pkg::OP_MULHSU,
         mdu_pkg::OP_MULHU:  prod_in = hi;
         mdu_pkg::OP_MULW:   prod_in = {{32{lo_ff[31]}}, lo_ff};
         default:            prod_in = 64'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff    <= ll_in;
         lh_ff    <= lh_in;
         hl_ff    <= hl_in;
         hh_ff    <= hh_in;
         corr_ff  <= corr_in;
         op1_ff   <= op;
         mid_ff   <= mid_in;
         lo_ff    <= ll_ff[31:0];
         hsum_ff  <= hsum_in;
         corr2_ff <= corr_ff;
         op2_ff   <= op1_ff;
         prod_ff  <= prod_in;
      end
   end

   assign product = prod_ff;

endmodule
`default_nettype wire

>>> rtl/mdu_div.sv
// fully pipelined restoring divider, one quotient bit per stage
`default_nettype none
module mdu_div (
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic [mdu_pkg::Xlen-1:0] dividend,
   input  wire logic [mdu_pkg::Xlen-1:0] divisor,
   output logic      [mdu_pkg::Xlen-1:0] quotient
);

   logic [63:0] rem_ff [mdu_pkg::DivSteps];
   logic [63:0] quo_ff [mdu_pkg::DivSteps];
   logic [63:0] dvs_ff [mdu_pkg::DivSteps];
   logic [63:0] rem_in [mdu_pkg::DivSteps];
   logic [63:0] quo_in [mdu_pkg::DivSteps];
   logic [63:0] src_rem, src_quo, src_dvs;
   logic [64:0] shifted, diff;

   // one shift and trial subtract per stage
   always_comb begin
      for (int i = 0; i < mdu_pkg::DivSteps; i++) begin
         src_rem = (i == 0) ? 64'b0 : rem_ff[(i == 0) ? 0 : i - 1];
         src_quo = (i == 0) ? dividend : quo_ff[(i == 0) ? 0 : i - 1];
         src_dvs = (i == 0) ? divisor : dvs_ff[(i == 0) ? 0 : i - 1];
         shifted = {src_rem, src_quo[63]};
         diff    = shifted - {1'b0, src_dvs};
         rem_in[i] = diff[64] ? shifted[63:0] : diff[63:0];
         quo_in[i] = {src_quo[62:0], ~diff[64]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < mdu_pkg::DivSteps; i++) begin
            rem_ff[i] <= rem_in[i];
            quo_ff[i] <= quo_in[i];
            dvs_ff[i] <= (i == 0) ? divisor : dvs_ff[(i == 0) ? 0 : i - 1];
         end
      end
   end

   assign quotient = quo_ff[mdu_pkg::DivSteps-1];

endmodule
`default_nettype wire

>>> rtl/rv64_mul_div_unit.sv
// top level of the rv64 multiply and divide unit
`default_nettype none
// One request per cycle enters and its response leaves through an input
// register, 64 divider stages that each produce one quotient bit, and the response
// register. Multiplies take three stages and ride a delay line to the same depth,
// so responses come back in request order. The whole pipeline holds while a
// response waits to be taken.
module rv64_mul_div_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [3:0]  req_operation,
   input  wire logic [63:0] req_operand_a,
   input  wire logic [63:0] req_operand_b,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_result
);

   logic en;
   mdu_pkg::op_type op;
   logic [31:0] a32, b32, a32_mag, b32_mag;

   // input stage
   mdu_pkg::ctl_type ctl_in, s0_ctl_ff;
   mdu_pkg::op_type s0_op_ff;
   logic [63:0] s0_a_ff, s0_b_ff, s0_dvd_ff, s0_dvs_ff, dvd_in, dvs_in;

   // control and multiply delay lines
   mdu_pkg::ctl_type ctl_ff [mdu_pkg::DivSteps];
   logic [63:0] mdl_ff [mdu_pkg::MulDelay];
   logic [63:0] mul_prod, div_quo, quo_sgn, res_in;

   logic rsp_valid_ff;
   logic [63:0] rsp_result_ff;

   // whole pipeline advances when the response slot is free or being taken
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // decode and operand magnitudes
   always_comb begin
      op      = mdu_pkg::op_type'(req_operation);
      a32     = req_operand_a[31:0];
      b32     = req_operand_b[31:0];
      a32_mag = a32[31] ? (32'b0 - a32) : a32;
      b32_mag = b32[31] ? (32'b0 - b32) : b32;
      ctl_in  = '0;
      ctl_in.valid = req_valid;
      dvd_in  = 64'b0;
      dvs_in  = 64'b0;
      case (op)
         mdu_pkg::OP_DIV: begin
            dvd_in = req_operand_a[63] ? (64'b0 - req_operand_a) : req_operand_a;
            dvs_in = req_operand_b[63] ? (64'b0 - req_operand_b) : req_operand_b;
            ctl_in.is_div  = 1'b1;
            ctl_in.neg     = req_operand_a[63] ^ req_operand_b[63];
            ctl_in.divzero = (req_operand_b == 64'b0);
         end
         mdu_pkg::OP_DIVU: begin
            dvd_in = req_operand_a;
            dvs_in = req_operand_b;
            ctl_in.is_div  = 1'b1;
            ctl_in.divzero = (req_operand_b == 64'b0);
         end
         mdu_pkg::OP_DIVW: begin
            dvd_in = {32'b0, a32_mag};
            dvs_in = {32'b0, b32_mag};
            ctl_in.is_div  = 1'b1;
            ctl_in.word    = 1'b1;
            ctl_in.neg     = a32[31] ^ b32[31];
            ctl_in.divzero = (b32 == 32'b0);
         end
         mdu_pkg::OP_DIVUW: begin
            dvd_in = {32'b0, a32};
            dvs_in = {32'b0, b32};
            ctl_in.is_div  = 1'b1;
            ctl_in.word    = 1'b1;
            ctl_in.divzero = (b32 == 32'b0);
         end
         default: begin
            dvd_in = 64'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ctl_ff <= '0;
      end else if (en) begin
         s0_ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_op_ff  <= op;
         s0_a_ff   <= req_operand_a;
         s0_b_ff   <= req_operand_b;
         s0_dvd_ff <= dvd_in;
         s0_dvs_ff <= dvs_in;
      end
   end

   mdu_mul u_mul (
      .clock     (clock),
      .en        (en),
      .op        (s0_op_ff),
      .operand_a (s0_a_ff),
      .operand_b (s0_b_ff),
      .product   (mul_prod)
   );

   mdu_div u_div (
      .clock    (clock),
      .en       (en),
      .dividend (s0_dvd_ff),
      .divisor  (s0_dvs_ff),
      .quotient (div_quo)
   );

   // control follows the divider stages
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mdu_pkg::DivSteps; i++) begin
            ctl_ff[i] <= '0;
         end
      end else if (en) begin
         for (int i = 0; i < mdu_pkg::DivSteps; i++) begin
            ctl_ff[i] <= (i == 0) ? s0_ctl_ff : ctl_ff[(i == 0) ? 0 : i - 1];
         end
      end
   end

   // multiply result waits for the divider depth
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < mdu_pkg::MulDelay; i++) begin
            mdl_ff[i] <= (i == 0) ? mul_prod : mdl_ff[(i == 0) ? 0 : i - 1];
         end
      end
   end

   // multiply result select, quotient sign, word extension and divide by zero
   always_comb begin
      quo_sgn = ctl_ff[mdu_pkg::DivSteps-1].neg ? (64'b0 - div_quo) : div_quo;
      if (!ctl_ff[mdu_pkg::DivSteps-1].is_div) begin
         res_in = mdl_ff[mdu_pkg::MulDelay-1];
      end else if (ctl_ff[mdu_pkg::DivSteps-1].divzero) begin
         res_in = {64{1'b1}};
      end else if (ctl_ff[mdu_pkg::DivSteps-1].word) begin
         res_in = {{32{quo_sgn[31]}}, quo_sgn[31:0]};
      end else begin
         res_in = quo_sgn;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= ctl_ff[mdu_pkg::DivSteps-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_result_ff <= res_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

   // a stalled pipeline keeps its last stage
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(ctl_ff[mdu_pkg::DivSteps-1]))
      else $error("last pipeline stage changed during stall");

   // divide by zero gives all ones
   a_divzero: assert property (@(posedge clock) disable iff (reset)
      (en && ctl_ff[mdu_pkg::DivSteps-1].valid && ctl_ff[mdu_pkg::DivSteps-1].is_div
       && ctl_ff[mdu_pkg::DivSteps-1].divzero) |=> (rsp_result == {64{1'b1}}))
      else $error("divide by zero result is not all ones");

   // a response that comes out matches an entry that was valid
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (en && !ctl_ff[mdu_pkg::DivSteps-1].valid) |=> !rsp_valid)
      else $error("response without a request in the last stage");

endmodule
`default_nettype wire

>>> tb/mdu_checker.sv
// checker that predicts and compares responses of the multiply and divide unit
module mdu_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [3:0]  req_operation,
   input  wire logic [63:0] req_operand_a,
   input  wire logic [63:0] req_operand_b,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [63:0] rsp_result,
   output int               error_count,
   output int               pending_count
);

   logic [63:0] expected_results[$];

   // sign-extend a 32-bit word
   function automatic logic [63:0] widen_word(input logic [31:0] w);
      return {{32{w[31]}}, w};
   endfunction

   // compute the rd value for one request
   function automatic logic [63:0] mdu_result(input logic [3:0] op, input logic [63:0] a,
                                               input logic [63:0] b);
      logic [127:0] prod;
      logic [63:0]  ma, mb, q;
      logic [31:0]  a32, b32, ma32, mb32, q32;
      a32 = a[31:0];
      b32 = b[31:0];
      case (op)
         mdu_pkg::OP_MUL: begin
            return a * b;
         end
         mdu_pkg::OP_MULH: begin
            prod = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
            return prod[127:64];
         end
         mdu_pkg::OP_MULHSU: begin
            prod = {{64{a[63]}}, a} * {64'd0, b};
            return prod[127:64];
         end
         mdu_pkg::OP_MULHU: begin
            prod = {64'd0, a} * {64'd0, b};
            return prod[127:64];
         end
         mdu_pkg::OP_DIV: begin
            if (b == 0) return '1;
            if (a == 64'h8000_0000_0000_0000 && b == '1) return a;
            ma = a[63] ? -a : a;
            mb = b[63] ? -b : b;
            q = ma / mb;
            return (a[63] != b[63]) ? -q : q;
         end
         mdu_pkg::OP_DIVU: begin
            return (b == 0) ? '1 : a / b;
         end
         mdu_pkg::OP_MULW: begin
            return widen_word(a32 * b32);
         end
         mdu_pkg::OP_DIVW: begin
            if (b32 == 0) return '1;
            if (a32 == 32'h8000_0000 && b32 == '1) return widen_word(a32);
            ma32 = a32[31] ? -a32 : a32;
            mb32 = b32[31] ? -b32 : b32;
            q32 = ma32 / mb32;
            return widen_word((a32[31] != b32[31]) ? -q32 : q32);
         end
         mdu_pkg::OP_DIVUW: begin
            return (b32 == 0) ? '1 : widen_word(a32 / b32);
         end
         default: begin
            return '0;
         end
      endcase
   endfunction

   // queue predictions on request, compare on response
   always @(posedge clock) begin
      logic [63:0] want;
      if (!reset) begin
         if (req_valid && req_ready)
            expected_results.push_back(mdu_result(req_operation, req_operand_a, req_operand_b));
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected response result=%h", rsp_result);
               error_count <= error_count + 1;
            end else begin
               want = expected_results.pop_front();
               if (want !== rsp_result) begin
                  $error("result mismatch: expected %h actual %h", want, rsp_result);
                  error_count <= error_count + 1;
               end
            end
         end
      end
      pending_count <= expected_results.size();
   end

   initial error_count = 0;

endmodule

>>> tb/tb.sv
// testbench top: stimulus, response stalls and verdict for the multiply and divide unit
module tb;

   localparam int Latency   = 66;
   localparam int IdleLimit = 20000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [3:0]  req_operation = '0;
   logic [63:0] req_operand_a = '0;
   logic [63:0] req_operand_b = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [63:0] rsp_result;
   int          error_count;
   int          pending_count;
   int          idle_cycles = 0;

   rv64_mul_div_unit dut (.*);

   mdu_checker checker_inst (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // pick an interesting 64-bit operand
   function automatic logic [63:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return 64'h8000_0000_0000_0000;
         3: return 64'h7fff_ffff_ffff_ffff;
         4: return {32'($urandom), 32'h8000_0000};
         5: return {32'($urandom), 32'hffff_ffff};
         6: return {32'($urandom), 32'd0};
         7: return 64'($urandom_range(0, 20));
         default: return {32'($urandom), 32'($urandom)};
      endcase
   endfunction

   // drive one request and wait for it to be taken
   task automatic send_request(input logic [3:0] op, input logic [63:0] a,
                               input logic [63:0] b);
      int gap;
      gap = $urandom_range(0, 13);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1;
      req_operation <= op;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // response side stalls
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         stall = $urandom_range(0, 13);
         if ($urandom_range(0, 3) == 0) stall = 0;
         if (stall > 0) begin
            rsp_ready <= 0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // watchdog on cycles with no transfer
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("FAIL rv64_mul_div_unit");
         $finish;
      end
   end

   initial begin
      logic [63:0] edge_vals[6];
      int          tail;
      edge_vals = '{64'd0, '1, 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff,
                    64'h0000_0000_8000_0000, 64'd7};
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: every operation, extremes, divide by zero and overflow
      for (int op = 0; op <= 8; op++) begin
         send_request(4'(op), '1, '1);
         send_request(4'(op), 64'h8000_0000_0000_0000, edge_vals[$urandom_range(0, 5)]);
      end
      send_request(mdu_pkg::OP_DIV, 64'h8000_0000_0000_0000, '1);
      send_request(mdu_pkg::OP_DIVW, 64'h1234_5678_8000_0000, 64'h0000_0001_ffff_ffff);
      send_request(mdu_pkg::OP_DIV, 64'd5, 64'd0);
      send_request(mdu_pkg::OP_DIVU, 64'd5, 64'd0);
      send_request(mdu_pkg::OP_DIVW, 64'd5, 64'hffff_ffff_0000_0000);
      send_request(mdu_pkg::OP_DIVUW, 64'd5, 64'h1_0000_0000);
      send_request(4'd15, '1, '1);
      req_valid <= 0;
      @(posedge clock);
      // hold off until the pipeline drains
      while (pending_count != 0) @(posedge clock);
      // random requests, occasionally unknown codes
      for (int i = 0; i < 1750; i++) begin
         send_request(($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                                   : 4'($urandom_range(0, 8)),
                      pick_operand(), pick_operand());
      end
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      tail = 0;
      while (tail < Latency + 10) begin
         @(posedge clock);
         tail++;
      end
      if (error_count == 0)
         $display("PASS rv64_mul_div_unit");
      else
         $display("FAIL rv64_mul_div_unit");
      $finish;
   end

endmodule
